/* src/mws_pkg.sv */
// ----------------------------------------------------------------------------
// mws_pkg: shared types and constants
// Word widths, the statistics record that travels from the front end through
// the queue to the back end, and the back-end state encoding.
// ----------------------------------------------------------------------------
package mws_pkg;

  localparam int WORD_W = 32;
  localparam int ACC_W  = 64;

  localparam logic [WORD_W-1:0] MAX_WORD = 32'hFFFF_FFFF;

  // snapshot of all running statistics after one transaction
  typedef struct packed {
    logic [ACC_W-1:0]  acc;
    logic [WORD_W-1:0] min_a;
    logic [WORD_W-1:0] max_a;
    logic [WORD_W-1:0] min_b;
    logic [WORD_W-1:0] max_b;
    logic [WORD_W-1:0] sum_a;
    logic [WORD_W-1:0] sum_b;
    logic [WORD_W-1:0] count;
  } stats_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } back_state_t;

endpackage

/* src/mws_front.sv */
// ----------------------------------------------------------------------------
// mws_front: input side
// Accepts operand pairs, updates min/max/sum/count, multiplies the operands
// into a product register and folds the product into the accumulator in the
// next cycle, in which it also pushes a statistics snapshot into the queue.
// ----------------------------------------------------------------------------
module mws_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mws_pkg::WORD_W-1:0] first_operand,
  input  logic [mws_pkg::WORD_W-1:0] second_operand,
  input  logic                       q_full,
  output logic                       push,
  output mws_pkg::stats_t            push_data
);

  logic [mws_pkg::ACC_W-1:0]  acc;
  logic [mws_pkg::ACC_W-1:0]  prod;
  logic [mws_pkg::ACC_W-1:0]  acc_next;
  logic [mws_pkg::WORD_W-1:0] min_a;
  logic [mws_pkg::WORD_W-1:0] max_a;
  logic [mws_pkg::WORD_W-1:0] min_b;
  logic [mws_pkg::WORD_W-1:0] max_b;
  logic [mws_pkg::WORD_W-1:0] sum_a;
  logic [mws_pkg::WORD_W-1:0] sum_b;
  logic [mws_pkg::WORD_W-1:0] count;
  logic                       pend;
  logic                       accept;

  // one transaction in flight through the product register at a time
  assign in_ready = !pend && !q_full;
  assign accept   = in_valid && in_ready;
  assign acc_next = acc + prod;

  // statistics, accumulator and pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      min_a <= mws_pkg::MAX_WORD;
      max_a <= '0;
      min_b <= mws_pkg::MAX_WORD;
      max_b <= '0;
      sum_a <= '0;
      sum_b <= '0;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      if (accept) begin
        if (first_operand < min_a) min_a <= first_operand;
        if (first_operand > max_a) max_a <= first_operand;
        if (second_operand < min_b) min_b <= second_operand;
        if (second_operand > max_b) max_b <= second_operand;
        sum_a <= sum_a + first_operand;
        sum_b <= sum_b + second_operand;
        if (count != mws_pkg::MAX_WORD) count <= count + 1'b1;
        pend  <= 1'b1;
      end else if (pend) begin
        acc  <= acc_next;
        pend <= 1'b0;
      end
    end
  end

  // full-width product, registered before the accumulate
  always_ff @(posedge clk) begin
    if (accept) begin
      prod <= {{mws_pkg::WORD_W{1'b0}}, first_operand} *
              {{mws_pkg::WORD_W{1'b0}}, second_operand};
    end
  end

  // snapshot pushed while the accumulate completes
  assign push = pend;
  always_comb begin
    push_data       = '0;
    push_data.acc   = acc_next;
    push_data.min_a = min_a;
    push_data.max_a = max_a;
    push_data.min_b = min_b;
    push_data.max_b = max_b;
    push_data.sum_a = sum_a;
    push_data.sum_b = sum_b;
    push_data.count = count;
  end

endmodule

/* src/mws_queue.sv */
// ----------------------------------------------------------------------------
// mws_queue: snapshot queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module mws_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mws_pkg::stats_t push_data,
  input  logic            pop,
  output mws_pkg::stats_t head,
  output logic            empty,
  output logic            full
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mws_pkg::stats_t  mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign empty = (fill == '0);
  assign full  = (fill == CNT_W'(DEPTH));
  assign head  = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");
`endif

endmodule

/* src/mws_div.sv */
// ----------------------------------------------------------------------------
// mws_div: dual restoring divider
// Two 32-bit dividends over one shared divisor, one quotient bit per lane
// per cycle.
// ----------------------------------------------------------------------------
module mws_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mws_pkg::WORD_W-1:0] dividend_a,
  input  logic [mws_pkg::WORD_W-1:0] dividend_b,
  input  logic [mws_pkg::WORD_W-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [mws_pkg::WORD_W-1:0] quot_a,
  output logic [mws_pkg::WORD_W-1:0] quot_b
);

  localparam int STEP_W = $clog2(mws_pkg::WORD_W);

  logic [mws_pkg::WORD_W-1:0] rem_a;
  logic [mws_pkg::WORD_W-1:0] rem_b;
  logic [mws_pkg::WORD_W-1:0] dvs;
  logic [STEP_W-1:0]          step;
  logic [mws_pkg::WORD_W:0]   sh_a;
  logic [mws_pkg::WORD_W:0]   sh_b;
  logic [mws_pkg::WORD_W:0]   dvs_x;
  logic                       ge_a;
  logic                       ge_b;
  logic [mws_pkg::WORD_W:0]   rem_a_next;
  logic [mws_pkg::WORD_W:0]   rem_b_next;

  assign done = busy && (step == STEP_W'(mws_pkg::WORD_W - 1));

  // one restoring step per lane
  always_comb begin
    dvs_x      = {1'b0, dvs};
    sh_a       = {rem_a, quot_a[mws_pkg::WORD_W-1]};
    sh_b       = {rem_b, quot_b[mws_pkg::WORD_W-1]};
    ge_a       = (sh_a >= dvs_x);
    ge_b       = (sh_b >= dvs_x);
    rem_a_next = ge_a ? sh_a - dvs_x : sh_a;
    rem_b_next = ge_b ? sh_b - dvs_x : sh_b;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (done) busy <= 1'b0;
    end
  end

  // datapath: quotient shifts in over the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      rem_a  <= '0;
      rem_b  <= '0;
      quot_a <= dividend_a;
      quot_b <= dividend_b;
      dvs    <= divisor;
    end else if (busy) begin
      rem_a  <= rem_a_next[mws_pkg::WORD_W-1:0];
      rem_b  <= rem_b_next[mws_pkg::WORD_W-1:0];
      quot_a <= {quot_a[mws_pkg::WORD_W-2:0], ge_a};
      quot_b <= {quot_b[mws_pkg::WORD_W-2:0], ge_b};
    end
  end

endmodule

/* src/mws_back.sv */
// ----------------------------------------------------------------------------
// mws_back: output side
// Pops a snapshot, runs both mean divisions and presents the result
// transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module mws_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  mws_pkg::stats_t            q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output mws_pkg::stats_t            res,
  output logic [mws_pkg::WORD_W-1:0] mean_a,
  output logic [mws_pkg::WORD_W-1:0] mean_b
);

  mws_pkg::back_state_t state;
  mws_pkg::back_state_t state_next;
  logic                 div_start;
  logic                 div_busy;
  logic                 div_done;

  mws_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .dividend_a (q_head.sum_a),
    .dividend_b (q_head.sum_b),
    .divisor    (q_head.count),
    .busy       (div_busy),
    .done       (div_done),
    .quot_a     (mean_a),
    .quot_b     (mean_b)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mws_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and outputs
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      mws_pkg::S_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          div_start  = 1'b1;
          state_next = mws_pkg::S_DIV;
        end
      end
      mws_pkg::S_DIV: begin
        if (div_done) state_next = mws_pkg::S_DONE;
      end
      mws_pkg::S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = mws_pkg::S_IDLE;
      end
      default: state_next = mws_pkg::S_IDLE;
    endcase
  end

  // hold the snapshot for the result transaction
  always_ff @(posedge clk) begin
    if (q_pop) begin
      res <= q_head;
    end
  end

`ifndef NO_ASSERTIONS
  a_result_after_divide: assert property (@(posedge clk) disable iff (rst)
      (state == mws_pkg::S_DONE) |-> !div_busy)
    else $error("result presented while divider still running");
  a_done_only_dividing: assert property (@(posedge clk) disable iff (rst)
      div_done |-> (state == mws_pkg::S_DIV))
    else $error("divider finished outside the divide state");
`endif

endmodule

/* src/mac_with_operand_statistics.sv */
// ----------------------------------------------------------------------------
// mac_with_operand_statistics: multiply-accumulate with operand statistics
// Usage:
//   Input channel (in_valid/in_ready) takes an operand pair per transaction.
//   Output channel (out_valid/out_ready) returns one result per transaction:
//   the 64-bit accumulator, min/max of each operand, the mean of each operand
//   and the saturating item count.
//   An accepted pair passes the product register, the accumulate and queue
//   write, the pop that starts the divider and the 32 division steps before
//   output valid rises.
//   The result rate is set by the 32-step radix-2 divider (both means in
//   parallel); the back end pops a snapshot only once the last result is
//   taken. The front end takes a pair once the last is pushed, while the queue
//   (QUEUE_DEPTH entries) has room, so it keeps taking input while a finished
//   result waits for the receiver. When the receiver stalls, the result holds
//   on the outputs and the queue fills, after which in_ready drops.
//   Reset (rst, synchronous): accumulator, sums and count go to zero,
//   minima to all ones, maxima to zero; queue and divider empty.
// ----------------------------------------------------------------------------
module mac_with_operand_statistics #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mws_pkg::WORD_W-1:0] first_operand,
  input  logic [mws_pkg::WORD_W-1:0] second_operand,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mws_pkg::ACC_W-1:0]  accumulated_sum,
  output logic [mws_pkg::WORD_W-1:0] smallest_first,
  output logic [mws_pkg::WORD_W-1:0] largest_first,
  output logic [mws_pkg::WORD_W-1:0] smallest_second,
  output logic [mws_pkg::WORD_W-1:0] largest_second,
  output logic [mws_pkg::WORD_W-1:0] mean_first,
  output logic [mws_pkg::WORD_W-1:0] mean_second,
  output logic [mws_pkg::WORD_W-1:0] items_seen
);

  logic            push;
  mws_pkg::stats_t push_data;
  logic            pop;
  mws_pkg::stats_t head;
  logic            q_empty;
  logic            q_full;
  mws_pkg::stats_t res;

  mws_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .first_operand  (first_operand),
    .second_operand (second_operand),
    .q_full         (q_full),
    .push           (push),
    .push_data      (push_data)
  );

  mws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  mws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (head),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res),
    .mean_a    (mean_first),
    .mean_b    (mean_second)
  );

  // result fields
  assign accumulated_sum = res.acc;
  assign smallest_first  = res.min_a;
  assign largest_first   = res.max_a;
  assign smallest_second = res.min_b;
  assign largest_second  = res.max_b;
  assign items_seen      = res.count;

endmodule

/* verif/mac_with_operand_statistics_tb.sv */
// ----------------------------------------------------------------------------
// mac_with_operand_statistics_tb: self-checking bench for the MAC/statistics
// Drives operand pairs through the valid/ready input channel and predicts the
// accumulator, operand min/max/mean and item count for every accepted
// transaction. Results from the output channel are checked field by field, in
// order. Both channels idle at random, with a stretch of no idling, one long
// receiver hold-off that backs up the input, and drain pauses.
// ----------------------------------------------------------------------------
module mac_with_operand_statistics_tb;

  localparam int unsigned RANDOM_ITEMS    = 1250;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned TAIL_CYCLES     = 40;
  localparam int unsigned CYCLE_LIMIT     = 600000;

  // one result transaction as seen on the output ports
  typedef struct {
    logic [mws_pkg::ACC_W-1:0]  acc;
    logic [mws_pkg::WORD_W-1:0] min_a;
    logic [mws_pkg::WORD_W-1:0] max_a;
    logic [mws_pkg::WORD_W-1:0] min_b;
    logic [mws_pkg::WORD_W-1:0] max_b;
    logic [mws_pkg::WORD_W-1:0] mean_a;
    logic [mws_pkg::WORD_W-1:0] mean_b;
    logic [mws_pkg::WORD_W-1:0] count;
  } mac_stats_t;

  // running MAC/statistics predictor plus the results still owed by the block
  class running_stats_model;
    logic [mws_pkg::ACC_W-1:0]  acc;
    logic [mws_pkg::WORD_W-1:0] min_a, max_a, min_b, max_b;
    logic [mws_pkg::WORD_W-1:0] sum_a, sum_b, count;
    mac_stats_t                 stats_due[$];
    int unsigned                errors;

    function new();
      acc    = '0;
      min_a  = mws_pkg::MAX_WORD;
      max_a  = '0;
      min_b  = mws_pkg::MAX_WORD;
      max_b  = '0;
      sum_a  = '0;
      sum_b  = '0;
      count  = '0;
      errors = 0;
    endfunction

    // update the statistics for one accepted operand pair
    function void take_operands(logic [mws_pkg::WORD_W-1:0] a,
                                logic [mws_pkg::WORD_W-1:0] b);
      mac_stats_t s;
      logic [mws_pkg::ACC_W-1:0] prod;
      prod = {{(mws_pkg::ACC_W-mws_pkg::WORD_W){1'b0}}, a} *
             {{(mws_pkg::ACC_W-mws_pkg::WORD_W){1'b0}}, b};
      acc  = acc + prod;
      if (a < min_a) min_a = a;
      if (a > max_a) max_a = a;
      if (b < min_b) min_b = b;
      if (b > max_b) max_b = b;
      sum_a = sum_a + a;
      sum_b = sum_b + b;
      if (count != mws_pkg::MAX_WORD) count = count + 1'b1;
      s.acc    = acc;
      s.min_a  = min_a;
      s.max_a  = max_a;
      s.min_b  = min_b;
      s.max_b  = max_b;
      s.mean_a = sum_a / count;  // count is at least one here
      s.mean_b = sum_b / count;
      s.count  = count;
      stats_due.push_back(s);
    endfunction

    function int unsigned outstanding();
      return stats_due.size();
    endfunction

    function void flag(string name, logic [mws_pkg::ACC_W-1:0] exp_v,
                       logic [mws_pkg::ACC_W-1:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                 $time, name, exp_v, act_v);
      end
    endfunction

    // compare one result transaction with the oldest prediction
    function void compare_stats(mac_stats_t r);
      mac_stats_t e;
      if (stats_due.size() == 0) begin
        errors++;
        $display("%0t: result with none pending: expected nothing, actual acc 0x%0h",
                 $time, r.acc);
        return;
      end
      e = stats_due.pop_front();
      flag("accumulated_sum", e.acc, r.acc);
      flag("smallest_first", e.min_a, r.min_a);
      flag("largest_first", e.max_a, r.max_a);
      flag("smallest_second", e.min_b, r.min_b);
      flag("largest_second", e.max_b, r.max_b);
      flag("mean_first", e.mean_a, r.mean_a);
      flag("mean_second", e.mean_b, r.mean_b);
      flag("items_seen", e.count, r.count);
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic [mws_pkg::WORD_W-1:0] first_operand;
  logic [mws_pkg::WORD_W-1:0] second_operand;
  logic                       out_valid;
  logic                       out_ready;
  logic [mws_pkg::ACC_W-1:0]  accumulated_sum;
  logic [mws_pkg::WORD_W-1:0] smallest_first;
  logic [mws_pkg::WORD_W-1:0] largest_first;
  logic [mws_pkg::WORD_W-1:0] smallest_second;
  logic [mws_pkg::WORD_W-1:0] largest_second;
  logic [mws_pkg::WORD_W-1:0] mean_first;
  logic [mws_pkg::WORD_W-1:0] mean_second;
  logic [mws_pkg::WORD_W-1:0] items_seen;

  running_stats_model stats = new();

  int unsigned tx_idle_pct = 36;
  int unsigned rx_idle_pct = 36;
  bit          hold_off_req = 1'b0;
  int unsigned cycles = 0;

  mac_with_operand_statistics u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .first_operand   (first_operand),
    .second_operand  (second_operand),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .accumulated_sum (accumulated_sum),
    .smallest_first  (smallest_first),
    .largest_first   (largest_first),
    .smallest_second (smallest_second),
    .largest_second  (largest_second),
    .mean_first      (mean_first),
    .mean_second     (mean_second),
    .items_seen      (items_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // input monitor: every accepted transaction feeds the predictor
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      stats.take_operands(first_operand, second_operand);
  end

  // output monitor
  always @(posedge clk) begin
    mac_stats_t r;
    if (!rst && out_valid && out_ready) begin
      r.acc    = accumulated_sum;
      r.min_a  = smallest_first;
      r.max_a  = largest_first;
      r.min_b  = smallest_second;
      r.max_b  = largest_second;
      r.mean_a = mean_first;
      r.mean_b = mean_second;
      r.count  = items_seen;
      stats.compare_stats(r);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // random idle cycles, then offer one operand pair until it is taken
  task automatic send_operands(input logic [mws_pkg::WORD_W-1:0] a,
                               input logic [mws_pkg::WORD_W-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    first_operand  <= a;
    second_operand <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and wait for every pending result; checked off the edge
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (stats.outstanding() != 0);
    @(posedge clk);
  endtask

  // operand mix: full random, small, near max, one-hot, one-cold
  function automatic logic [mws_pkg::WORD_W-1:0] pick_word();
    unique case ($urandom_range(5))
      0:       return $urandom_range(15);
      1:       return mws_pkg::MAX_WORD - $urandom_range(15);
      2:       return 32'h1 << $urandom_range(31);
      3:       return ~(32'h1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  // directed pairs: zero, extremes, full-width product, patterns, wraps
  localparam int unsigned N_DIRECTED = 20;
  logic [mws_pkg::WORD_W-1:0] dir_a [N_DIRECTED] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000,
    32'hFFFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0001_0000, 32'h7FFF_FFFF,
    32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0000_0002, 32'hFFFF_FFFF
  };
  logic [mws_pkg::WORD_W-1:0] dir_b [N_DIRECTED] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'h0000_0000, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0001,
    32'h0000_0000, 32'hFFFF_FFFF, 32'h8765_4321, 32'hFFFF_FFFF, 32'hFFFF_FFFF
  };

  // main sequence
  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    first_operand  = '0;
    second_operand = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: the repeated all-ones pairs wrap both sums and the
    // accumulator; count saturation needs 2^32 - 1 transactions, out of reach
    for (int i = 0; i < N_DIRECTED; i++)
      send_operands(dir_a[i], dir_b[i]);
    drain_results();

    // random part with a no-idle stretch, a long hold-off and a drain pause
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= 300 && i < 600) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = 36;
        rx_idle_pct = 36;
      end
      if (i == 700) hold_off_req = 1'b1;
      if (i == 950) drain_results();
      send_operands(pick_word(), pick_word());
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (stats.errors == 0 && stats.outstanding() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
